### sv/msqpt_pkg.sv
// package: types, constants and controller states for the queue peak tracker
`default_nettype none
package msqpt_pkg;
  localparam int SERVERS_DEF     = 16;
  localparam int QUEUE_DEPTH_DEF = 1024;
  localparam int ARR_W  = 40;
  localparam int SVC_W  = 32;
  localparam int FIN_W  = 41;
  localparam int OCC_W  = 11;
  localparam int NS_W   = 5;
  localparam logic [0:0] REG_NUM_SERVERS = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RELEASE,
    ST_RDWAIT,
    ST_PLACE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic scan_start;
    logic scan_step;
    logic release_go;
    logic pop_go;
    logic place_go;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic pick_found;
    logic wait_nonempty;
  } sts_t;
endpackage
`default_nettype wire

### sv/msqpt_ctrl.sv
// controller: sequences release scans, queue pops and job placement
`default_nettype none
module msqpt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  input  wire logic          out_slot_free,
  input  wire msqpt_pkg::sts_t sts,
  output msqpt_pkg::cmd_t    cmd,
  output logic               busy
);
  msqpt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= msqpt_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != msqpt_pkg::ST_IDLE);
    unique case (state_r)
      msqpt_pkg::ST_IDLE: begin
        if (in_fire) begin
          cmd.scan_start = 1'b1;
          state_nxt = msqpt_pkg::ST_SCAN;
        end
      end
      msqpt_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = msqpt_pkg::ST_RELEASE;
      end
      msqpt_pkg::ST_RELEASE: begin
        if (!sts.pick_found) begin
          state_nxt = msqpt_pkg::ST_PLACE;
        end else if (sts.wait_nonempty) begin
          state_nxt = msqpt_pkg::ST_RDWAIT;
        end else begin
          cmd.release_go = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt = msqpt_pkg::ST_SCAN;
        end
      end
      msqpt_pkg::ST_RDWAIT: begin
        cmd.pop_go = 1'b1;
        cmd.scan_start = 1'b1;
        state_nxt = msqpt_pkg::ST_SCAN;
      end
      msqpt_pkg::ST_PLACE: begin
        if (out_slot_free) begin
          cmd.place_go = 1'b1;
          state_nxt = msqpt_pkg::ST_OUT;
        end
      end
      msqpt_pkg::ST_OUT: begin
        cmd.out_load = 1'b1;
        state_nxt = msqpt_pkg::ST_IDLE;
      end
      default: state_nxt = msqpt_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### sv/msqpt_datapath.sv
// datapath: server table, serial minimum search, waiting line memory, counters
`default_nettype none
module msqpt_datapath #(
  parameter int SERVERS     = msqpt_pkg::SERVERS_DEF,
  parameter int QUEUE_DEPTH = msqpt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_fire,
  input  wire logic [msqpt_pkg::ARR_W-1:0]   in_arrival,
  input  wire logic [msqpt_pkg::SVC_W-1:0]   in_service,
  input  wire logic [msqpt_pkg::NS_W-1:0]    num_servers,
  input  wire msqpt_pkg::cmd_t               cmd,
  output msqpt_pkg::sts_t                    sts,
  output logic [msqpt_pkg::OCC_W-1:0]        res_peak,
  output logic [msqpt_pkg::OCC_W-1:0]        res_occ,
  output logic                               res_ovf
);
  localparam int SI_W = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int SC_W = $clog2(SERVERS + 1);
  localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int OC_W = $clog2(SERVERS + QUEUE_DEPTH + 1);

  logic [msqpt_pkg::FIN_W-1:0] fin_r [SERVERS];
  logic [SERVERS-1:0]          busyv_r;
  logic [SC_W-1:0]             busy_cnt_r;
  logic [msqpt_pkg::SVC_W-1:0] qmem [QUEUE_DEPTH];
  logic [msqpt_pkg::SVC_W-1:0] qrd_r;
  logic [QA_W-1:0]             head_r;
  logic [QC_W-1:0]             wcnt_r;
  logic [OC_W-1:0]             peak_r;
  logic [msqpt_pkg::ARR_W-1:0] arr_r;
  logic [msqpt_pkg::SVC_W-1:0] svc_r;
  logic [SC_W-1:0]             idx_r;
  logic                        found_r;
  logic [SI_W-1:0]             pick_r;
  logic [msqpt_pkg::FIN_W-1:0] pfin_r;
  logic                        ovf_r;

  logic [SI_W-1:0]             idx_s;
  logic [msqpt_pkg::FIN_W-1:0] cur_fin;
  logic                        better;
  logic [SC_W-1:0]             lim;
  logic [SI_W-1:0]             free_idx;
  logic                        free_ok;
  logic [QA_W:0]               tail_sum;
  logic [QA_W-1:0]             tail;
  logic [OC_W-1:0]             occ_nxt;
  logic                        do_place;
  logic                        do_queue;

  assign idx_s   = idx_r[SI_W-1:0];
  assign cur_fin = fin_r[idx_s];
  assign better  = busyv_r[idx_s] && (cur_fin <= {1'b0, arr_r}) &&
                   (!found_r || (cur_fin < pfin_r));

  always_comb begin
    if (num_servers == '0)                          lim = SC_W'(1);
    else if (32'(num_servers) > 32'(SERVERS))       lim = SC_W'(SERVERS);
    else                                            lim = SC_W'(num_servers);
  end

  always_comb begin
    free_idx = '0;
    free_ok  = 1'b0;
    for (int s = SERVERS - 1; s >= 0; s--) begin
      if (!busyv_r[s]) begin
        free_idx = SI_W'(s);
        free_ok  = 1'b1;
      end
    end
  end

  // head plus count wraps at the line depth
  assign tail_sum = {1'b0, head_r} + (QA_W + 1)'(wcnt_r);
  assign tail     = (32'(tail_sum) >= QUEUE_DEPTH) ? QA_W'(32'(tail_sum) - QUEUE_DEPTH)
                                                   : QA_W'(tail_sum);
  assign do_place = (busy_cnt_r < lim) && free_ok;
  assign do_queue = !do_place && (32'(wcnt_r) < 32'(QUEUE_DEPTH));
  assign sts.scan_done     = (32'(idx_r) == SERVERS - 1);
  assign sts.pick_found    = found_r;
  assign sts.wait_nonempty = (wcnt_r != '0);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      arr_r <= in_arrival;
      svc_r <= in_service;
    end
    if (cmd.scan_start) begin
      idx_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.scan_step) begin
      if (better) begin
        found_r <= 1'b1;
        pick_r  <= idx_s;
        pfin_r  <= cur_fin;
      end
      if (!sts.scan_done) idx_r <= idx_r + SC_W'(1);
    end
    qrd_r <= qmem[head_r];
    if (cmd.place_go && do_queue) qmem[tail] <= svc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busyv_r    <= '0;
      busy_cnt_r <= '0;
      head_r     <= '0;
      wcnt_r     <= '0;
      peak_r     <= '0;
      ovf_r      <= 1'b0;
      for (int s = 0; s < SERVERS; s++) fin_r[s] <= '0;
    end else begin
      if (cmd.release_go) begin
        busyv_r[pick_r] <= 1'b0;
        fin_r[pick_r]   <= '0;
        busy_cnt_r      <= busy_cnt_r - SC_W'(1);
      end
      if (cmd.pop_go) begin
        fin_r[pick_r] <= pfin_r + msqpt_pkg::FIN_W'(qrd_r);
        head_r        <= (32'(head_r) == QUEUE_DEPTH - 1) ? '0 : QA_W'(32'(head_r) + 1);
        wcnt_r        <= wcnt_r - QC_W'(1);
      end
      if (cmd.place_go) begin
        ovf_r <= !do_place && !do_queue;
        if (do_place) begin
          busyv_r[free_idx] <= 1'b1;
          fin_r[free_idx]   <= msqpt_pkg::FIN_W'(arr_r) + msqpt_pkg::FIN_W'(svc_r);
          busy_cnt_r        <= busy_cnt_r + SC_W'(1);
        end else if (do_queue) begin
          wcnt_r <= wcnt_r + QC_W'(1);
        end
      end
      if (cmd.out_load && (occ_nxt > peak_r)) peak_r <= occ_nxt;
    end
  end

  assign occ_nxt  = OC_W'(busy_cnt_r) + OC_W'(wcnt_r);
  assign res_occ  = msqpt_pkg::OCC_W'(occ_nxt);
  assign res_peak = (occ_nxt > peak_r) ? msqpt_pkg::OCC_W'(occ_nxt)
                                       : msqpt_pkg::OCC_W'(peak_r);
  assign res_ovf  = ovf_r;

`ifndef ASSERT_OFF
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    32'(busy_cnt_r) == $countones(busyv_r)) else $error("busy count mismatch");
  a_wcnt: assert property (@(posedge clk) disable iff (!rst_n)
    32'(wcnt_r) <= QUEUE_DEPTH) else $error("wait count beyond depth");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_go |-> (found_r && wcnt_r != '0)) else $error("pop without pick");
  a_rel: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.release_go |-> (found_r && busyv_r[pick_r])) else $error("bad release");
`endif
endmodule
`default_nettype wire

### sv/multi_server_queue_peak_tracker_unit.sv
// top level: stream ports, register port, controller and datapath
// Each job takes one serial scan of all servers, plus one more scan per released
// server, with a queue pop before that scan when the released server picks up
// a waiting job, and then a placement, which waits for a free result slot, and
// a result load. The scan loop over the server finish times dominates the job
// time. One job is handled at a time; the result register lets the next job be
// taken while a result waits.
`default_nettype none
module multi_server_queue_peak_tracker_unit #(
  parameter int SERVERS     = msqpt_pkg::SERVERS_DEF,
  parameter int QUEUE_DEPTH = msqpt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,    // arrival_time[39:0], service_time[71:40]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,   // peak_occupancy[10:0], current_occupancy[21:11],
                                        // queue_overflow[22], zero[23]
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  logic [msqpt_pkg::NS_W-1:0] ns_r;
  logic                       busy;
  logic                       in_fire;
  logic                       out_full_r;
  logic [23:0]                out_data_r;
  msqpt_pkg::cmd_t            cmd;
  msqpt_pkg::sts_t            sts;
  logic [msqpt_pkg::OCC_W-1:0] r_peak, r_occ;
  logic                       r_ovf;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == msqpt_pkg::REG_NUM_SERVERS) ? {27'd0, ns_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) ns_r <= msqpt_pkg::NS_W'(1);
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
             cfg_paddr[2] == msqpt_pkg::REG_NUM_SERVERS && cfg_paddr[1:0] == 2'b00)
      ns_r <= cfg_pwdata[msqpt_pkg::NS_W-1:0];
  end

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) out_full_r <= 1'b0;
    else if (cmd.out_load) out_full_r <= 1'b1;
    else if (out_tready) out_full_r <= 1'b0;
    if (cmd.out_load) out_data_r <= {1'b0, r_ovf, r_occ, r_peak};
  end
  assign out_tvalid = out_full_r;
  assign out_tdata  = out_data_r;

  msqpt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .out_slot_free(!out_full_r || out_tready),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  msqpt_datapath #(.SERVERS(SERVERS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .in_arrival(in_tdata[39:0]), .in_service(in_tdata[71:40]),
    .num_servers(ns_r), .cmd(cmd), .sts(sts),
    .res_peak(r_peak), .res_occ(r_occ), .res_ovf(r_ovf)
  );
endmodule
`default_nettype wire

### tb/testbench.sv
// testbench for the queue peak tracker: random jobs checked against a behavioral predictor
`timescale 1ns / 1ps
`default_nettype none

class occupancy_scoreboard;
  localparam int NSRV = 16;
  localparam int QDEPTH = 1024;
  logic [40:0] finish_at [NSRV];
  bit busy [NSRV];
  logic [31:0] line_svc [QDEPTH];
  int unsigned line_head;
  int unsigned line_count;
  int unsigned peak;
  int unsigned servers_cfg;
  logic [23:0] pending [$];
  int errors;

  function new();
    for (int s = 0; s < NSRV; s++) begin
      finish_at[s] = '0;
      busy[s] = 0;
    end
    line_head = 0;
    line_count = 0;
    peak = 0;
    servers_cfg = 1;
    errors = 0;
  endfunction

  function void set_servers(logic [31:0] v);
    servers_cfg = v[4:0];
  endfunction

  function int unsigned busy_now();
    int unsigned n;
    n = 0;
    for (int s = 0; s < NSRV; s++) if (busy[s]) n++;
    return n;
  endfunction

  function void note_job(logic [39:0] arr, logic [31:0] svc);
    int pick;
    int unsigned lim;
    int unsigned occ;
    bit ovf;
    logic [23:0] exp_item;
    ovf = 0;
    forever begin
      pick = -1;
      for (int s = 0; s < NSRV; s++)
        if (busy[s] && finish_at[s] <= {1'b0, arr} &&
            (pick < 0 || finish_at[s] < finish_at[pick])) pick = s;
      if (pick < 0) break;
      if (line_count > 0) begin
        finish_at[pick] = finish_at[pick] + line_svc[line_head];
        line_head = (line_head + 1) % QDEPTH;
        line_count--;
      end else begin
        busy[pick] = 0;
        finish_at[pick] = '0;
      end
    end
    lim = (servers_cfg == 0) ? 1 : (servers_cfg > NSRV ? NSRV : servers_cfg);
    if (busy_now() < lim) begin
      for (int s = 0; s < NSRV; s++)
        if (!busy[s]) begin
          busy[s] = 1;
          finish_at[s] = {1'b0, arr} + svc;
          break;
        end
    end else if (line_count >= QDEPTH) begin
      ovf = 1;
    end else begin
      line_svc[(line_head + line_count) % QDEPTH] = svc;
      line_count++;
    end
    occ = busy_now() + line_count;
    if (occ > peak) peak = occ;
    exp_item = {1'b0, ovf, occ[10:0], peak[10:0]};
    pending = {pending, exp_item};
  endfunction

  function void check_result(logic [23:0] got);
    logic [23:0] exp_r;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", got);
      return;
    end
    exp_r = pending.pop_front();
    if (got[10:0] !== exp_r[10:0] || got[21:11] !== exp_r[21:11] ||
        got[22] !== exp_r[22]) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected peak %0d occ %0d ovf %0d, got peak %0d occ %0d ovf %0d",
                 exp_r[10:0], exp_r[21:11], exp_r[22], got[10:0], got[21:11], got[22]);
    end
  endfunction
endclass

module testbench;
  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [71:0] in_tdata;   // arrival_time[39:0], service_time[71:40]
  logic out_tvalid;
  logic out_tready;
  logic [23:0] out_tdata;  // peak[10:0], current[21:11], overflow[22], zero[23]
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  occupancy_scoreboard board;
  logic [39:0] clock_now;
  bit stim_done;

  multi_server_queue_peak_tracker_unit u_dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #80ms;
    $display("simulation failed");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic write_servers(logic [31:0] v);
    @(posedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= {msqpt_pkg::REG_NUM_SERVERS, 2'b00};
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    board.set_servers(v);
  endtask

  task automatic send_job(logic [39:0] arr, logic [31:0] svc, bit may_gap);
    int g;
    g = may_gap ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {svc, arr};
    do @(posedge clk); while (!in_tready);
    board.note_job(arr, svc);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_phase(int n, int unsigned step_max, int unsigned svc_max);
    logic [31:0] svc;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) clock_now = 40'({$urandom, $urandom});
      else clock_now = clock_now + $urandom_range(0, step_max);
      if ($urandom_range(0, 15) == 0) svc = $urandom;
      else svc = $urandom_range(0, svc_max);
      send_job(clock_now, svc, 1);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_result(out_tdata);
      if (stim_done || $urandom_range(0, 3) != 0)
        out_tready <= (gap_len() == 0) || stim_done;
      else
        out_tready <= 1;
    end
  end

  initial begin
    board = new();
    rst_n = 0; in_tvalid = 0; in_tdata = '0; out_tready = 0; stim_done = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    clock_now = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: field extremes, zero service, equal finishes, server count edge values
    send_job(40'd0, 32'd0, 0);
    send_job(40'd0, 32'hFFFF_FFFF, 0);
    send_job(40'd0, 32'd5, 0);
    send_job(40'd10, 32'd0, 0);
    drain();
    write_servers(32'd0);
    send_job(40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_job(40'hFF_FFFF_FFFF, 32'd0, 0);
    drain();
    write_servers(32'd31);
    for (int i = 0; i < 18; i++) send_job(40'h10_0000_0000, 32'd7, 1);
    drain();
    write_servers(32'd3);
    send_job(40'h10_0000_0000, 32'd0, 0);
    send_job(40'h20_0000_0000, 32'd1, 0);
    send_job(40'd5, 32'hAAAA_5555, 0);
    drain();

    clock_now = 40'h20_0000_0010;
    write_servers(32'd1);
    random_phase(150, 20, 30);
    drain();
    write_servers(32'd16);
    random_phase(150, 3, 100);
    drain();
    write_servers(32'd2);
    // heavy load builds a long waiting line
    random_phase(300, 0, 2);
    drain();
    write_servers($urandom_range(1, 16));
    random_phase(100, 10, 60);
    drain();
    write_servers(32'd17 + $urandom_range(0, 14));
    random_phase(100, 2, 40);
    drain();
    write_servers(32'd4);
    random_phase(100, 8, 40);
    stim_done = 1;
    drain();

    if (board.errors == 0 && board.pending.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

### multi_server_queue_peak_tracker_unit.f
sv/msqpt_pkg.sv
sv/msqpt_ctrl.sv
sv/msqpt_datapath.sv
sv/multi_server_queue_peak_tracker_unit.sv
tb/testbench.sv
